FILE: rtl/core/handler_duration_monitor_assert.svh
// Assertion macros shared by the handler duration monitor checkers.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef HANDLER_DURATION_MONITOR_ASSERT_SVH
`define HANDLER_DURATION_MONITOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HDM_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HDM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/hdm_pkg.sv
// Package for the handler duration monitor: widths, codes, state and bundle types.
// No dependencies.
`default_nettype none

package hdm_pkg;

  localparam int SOFT_KINDS = 10;
  localparam int SLOW_SHIFT = 20;
  localparam int NUM_SLOTS  = SOFT_KINDS + 2;
  localparam int SLOT_W     = $clog2(NUM_SLOTS);

  localparam int MODE_W    = 3;
  localparam int TS_W      = 64;
  localparam int SIDX_W    = 4;
  localparam int HID_W     = 32;
  localparam int CNT_W     = 32;
  localparam int SRC_W     = 2;
  localparam int THR_W     = 12;
  localparam int CFG_IDX_W = 2;

  localparam logic [MODE_W-1:0] MODE_IRQ_ENTRY   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_IRQ_EXIT    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SOFT_ENTRY  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SOFT_EXIT   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TIMER_ENTRY = 3'd4;
  localparam logic [MODE_W-1:0] MODE_TIMER_EXIT  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_DUMP        = 3'd6;

  localparam logic [SRC_W-1:0] SRC_IRQ   = 2'd0;
  localparam logic [SRC_W-1:0] SRC_SOFT  = 2'd1;
  localparam logic [SRC_W-1:0] SRC_TIMER = 2'd2;

  localparam logic KIND_SLOW    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_IRQ_THR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOFT_THR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_THR = 2'd2;

  localparam logic [THR_W-1:0] IRQ_THR_RESET   = 12'd5;
  localparam logic [THR_W-1:0] SOFT_THR_RESET  = 12'd10;
  localparam logic [THR_W-1:0] TIMER_THR_RESET = 12'd10;

  localparam logic [SLOT_W-1:0] IRQ_SLOT   = '0;
  localparam logic [SLOT_W-1:0] TIMER_SLOT = SLOT_W'(NUM_SLOTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXIT,
    ST_DUMP
  } state_t;

  typedef struct packed {
    logic take;
    logic exit_upd;
    logic dump_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_exit;
    logic in_dump;
    logic exit_slow;
    logic out_free;
    logic slot_last;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/hdm_if.sv
// Channel interfaces of the handler duration monitor: input events and output records.
// Depends on hdm_pkg.
`default_nettype none

interface hdm_in_if;
  import hdm_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [TS_W-1:0]   timestamp_ns;
  logic              nested;
  logic              handled;
  logic [SIDX_W-1:0] softirq_index;
  logic [HID_W-1:0]  handler_id;

  modport source (
    output valid, mode, timestamp_ns, nested, handled, softirq_index, handler_id,
    input  ready
  );

  modport sink (
    input  valid, mode, timestamp_ns, nested, handled, softirq_index, handler_id,
    output ready
  );
endinterface

interface hdm_out_if;
  import hdm_pkg::*;

  logic              valid;
  logic              ready;
  logic              record_kind;
  logic [SRC_W-1:0]  record_source;
  logic [SIDX_W-1:0] out_softirq_index;
  logic [HID_W-1:0]  out_handler_id;
  logic [TS_W-1:0]   duration_ns;
  logic [CNT_W-1:0]  event_count;
  logic [TS_W-1:0]   total_ns;
  logic              last;

  modport source (
    output valid, record_kind, record_source, out_softirq_index, out_handler_id,
           duration_ns, event_count, total_ns, last,
    input  ready
  );

  modport sink (
    input  valid, record_kind, record_source, out_softirq_index, out_handler_id,
           duration_ns, event_count, total_ns, last,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/handler_duration_monitor.sv
// Top level of the handler duration monitor: controller, datapath and channel wiring.
// Depends on hdm_pkg, hdm_if, hdm_ctrl and hdm_dp.
//
//   Channel   Direction  Handshake        Beat
//   in_ch     sink       valid / ready    one entry, exit or dump event
//   out_ch    source     valid / ready    one slow-event or summary record
//   cfg       write      cfg_we           one threshold register
//
// An entry event or an ignored event is taken in the idle state; an exit also passes
// through the exit state, where the counter read-modify-write is done.
// A dump passes through the dump state and issues twelve summaries in all, each
// issued as the output register frees.
// Reset is synchronous and restores the thresholds and clears stamps and counters.
// A stalled output holds its record; a slow exit or a dump then waits for it.
`default_nettype none

module handler_duration_monitor (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire [hdm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [hdm_pkg::THR_W-1:0]     cfg_data,
  hdm_in_if.sink                       in_ch,
  hdm_out_if.source                    out_ch
);
  import hdm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  hdm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  hdm_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_mode          (in_ch.mode),
    .in_timestamp_ns  (in_ch.timestamp_ns),
    .in_nested        (in_ch.nested),
    .in_handled       (in_ch.handled),
    .in_softirq_index (in_ch.softirq_index),
    .in_handler_id    (in_ch.handler_id),
    .cmd              (cmd),
    .status           (status),
    .out_ch           (out_ch)
  );

endmodule

`default_nettype wire

FILE: rtl/core/hdm_ctrl.sv
// Controller state machine of the handler duration monitor.
// Depends on hdm_pkg; drives commands to hdm_dp and reads its status.
`default_nettype none

module hdm_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  hdm_pkg::dp_status_t status,
  output hdm_pkg::ctrl_cmd_t  cmd
);
  import hdm_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (status.in_exit) begin
            state_next = ST_EXIT;
          end else if (status.in_dump) begin
            state_next = ST_DUMP;
          end
        end
      end
      ST_EXIT: begin
        if (!status.exit_slow || status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_DUMP: begin
        if (status.out_free && status.slot_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.take      = 1'b0;
    cmd.exit_upd  = 1'b0;
    cmd.dump_step = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_EXIT: begin
        cmd.exit_upd = !status.exit_slow || status.out_free;
      end
      ST_DUMP: begin
        cmd.dump_step = status.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/hdm_dp.sv
// Datapath of the handler duration monitor: thresholds, start stamps, counter slots
// and the output record register. Depends on hdm_pkg and hdm_out_if.
`default_nettype none

module hdm_dp (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire [hdm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [hdm_pkg::THR_W-1:0]         cfg_data,
  input  wire [hdm_pkg::MODE_W-1:0]        in_mode,
  input  wire [hdm_pkg::TS_W-1:0]          in_timestamp_ns,
  input  wire                              in_nested,
  input  wire                              in_handled,
  input  wire [hdm_pkg::SIDX_W-1:0]        in_softirq_index,
  input  wire [hdm_pkg::HID_W-1:0]         in_handler_id,
  input  hdm_pkg::ctrl_cmd_t               cmd,
  output hdm_pkg::dp_status_t              status,
  hdm_out_if.source                        out_ch
);
  import hdm_pkg::*;

  logic [THR_W-1:0]  irq_thr;
  logic [THR_W-1:0]  soft_thr;
  logic [THR_W-1:0]  timer_thr;
  logic [TS_W-1:0]   irq_start;
  logic [TS_W-1:0]   soft_start;
  logic [TS_W-1:0]   timer_start;
  logic [CNT_W-1:0]  slot_cnt [NUM_SLOTS];
  logic [TS_W-1:0]   slot_tot [NUM_SLOTS];

  logic [SRC_W-1:0]  item_src;
  logic [SLOT_W-1:0] item_slot;
  logic [SIDX_W-1:0] item_sidx;
  logic [HID_W-1:0]  item_hid;
  logic [TS_W-1:0]   elapsed;
  logic [SLOT_W-1:0] ptr;
  logic              out_valid;

  logic [TS_W-1:0]   start_sel;
  logic              exit_ok;
  logic              soft_ok;
  logic [SRC_W-1:0]  src_next;
  logic [SLOT_W-1:0] slot_next;
  logic [SIDX_W-1:0] sidx_next;
  logic [THR_W-1:0]  thr_sel;
  logic [CNT_W-1:0]  cnt_sel;
  logic [CNT_W-1:0]  cnt_inc;
  logic              load_slow;
  logic              load_any;

  assign soft_ok = int'(in_softirq_index) < SOFT_KINDS;

  always_comb begin
    start_sel = '0;
    exit_ok   = 1'b0;
    src_next  = SRC_IRQ;
    slot_next = IRQ_SLOT;
    sidx_next = '0;
    case (in_mode)
      MODE_IRQ_EXIT: begin
        start_sel = irq_start;
        exit_ok   = !in_nested && in_handled;
      end
      MODE_SOFT_EXIT: begin
        start_sel = soft_start;
        exit_ok   = soft_ok;
        src_next  = SRC_SOFT;
        slot_next = SLOT_W'(in_softirq_index) + SLOT_W'(1);
        sidx_next = in_softirq_index;
      end
      MODE_TIMER_EXIT: begin
        start_sel = timer_start;
        exit_ok   = 1'b1;
        src_next  = SRC_TIMER;
        slot_next = TIMER_SLOT;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (item_src)
      SRC_IRQ:  thr_sel = irq_thr;
      SRC_SOFT: thr_sel = soft_thr;
      default:  thr_sel = timer_thr;
    endcase
  end

  assign cnt_sel   = slot_cnt[item_slot];
  assign cnt_inc   = (cnt_sel == '1) ? cnt_sel : cnt_sel + CNT_W'(1);
  assign load_slow = cmd.exit_upd && status.exit_slow;
  assign load_any  = load_slow || cmd.dump_step;

  always_comb begin
    status.in_exit   = exit_ok && (start_sel != '0);
    status.in_dump   = in_mode == MODE_DUMP;
    status.exit_slow = (thr_sel != '0) && ((elapsed >> SLOW_SHIFT) >= TS_W'(thr_sel));
    status.out_free  = !out_valid || out_ch.ready;
    status.slot_last = ptr == TIMER_SLOT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      irq_thr     <= IRQ_THR_RESET;
      soft_thr    <= SOFT_THR_RESET;
      timer_thr   <= TIMER_THR_RESET;
      irq_start   <= '0;
      soft_start  <= '0;
      timer_start <= '0;
      ptr         <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_cnt[i] <= '0;
        slot_tot[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IRQ_THR:   irq_thr   <= cfg_data;
          CFG_SOFT_THR:  soft_thr  <= cfg_data;
          CFG_TIMER_THR: timer_thr <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.take) begin
        ptr <= '0;
        case (in_mode)
          MODE_IRQ_ENTRY: begin
            if (!in_nested) begin
              irq_start <= in_timestamp_ns;
            end
          end
          MODE_SOFT_ENTRY: begin
            if (soft_ok) begin
              soft_start <= in_timestamp_ns;
            end
          end
          MODE_TIMER_ENTRY: begin
            timer_start <= in_timestamp_ns;
          end
          default: begin
          end
        endcase
      end
      if (cmd.exit_upd) begin
        slot_cnt[item_slot] <= cnt_inc;
        slot_tot[item_slot] <= slot_tot[item_slot] + elapsed;
      end
      if (cmd.dump_step) begin
        slot_cnt[ptr] <= '0;
        slot_tot[ptr] <= '0;
        ptr           <= ptr + SLOT_W'(1);
      end
      if (load_any) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_src  <= src_next;
      item_slot <= slot_next;
      item_sidx <= sidx_next;
      item_hid  <= in_handler_id;
      elapsed   <= in_timestamp_ns - start_sel;
    end
    if (load_slow) begin
      out_ch.record_kind       <= KIND_SLOW;
      out_ch.record_source     <= item_src;
      out_ch.out_softirq_index <= item_sidx;
      out_ch.out_handler_id    <= item_hid;
      out_ch.duration_ns       <= elapsed;
      out_ch.event_count       <= '0;
      out_ch.total_ns          <= '0;
      out_ch.last              <= 1'b1;
    end else if (cmd.dump_step) begin
      out_ch.record_kind    <= KIND_SUMMARY;
      out_ch.out_handler_id <= '0;
      out_ch.duration_ns    <= '0;
      out_ch.event_count    <= slot_cnt[ptr];
      out_ch.total_ns       <= slot_tot[ptr];
      out_ch.last           <= ptr == TIMER_SLOT;
      if (ptr == IRQ_SLOT) begin
        out_ch.record_source     <= SRC_IRQ;
        out_ch.out_softirq_index <= '0;
      end else if (ptr == TIMER_SLOT) begin
        out_ch.record_source     <= SRC_TIMER;
        out_ch.out_softirq_index <= '0;
      end else begin
        out_ch.record_source     <= SRC_SOFT;
        out_ch.out_softirq_index <= SIDX_W'(ptr - SLOT_W'(1));
      end
    end
  end

  assign out_ch.valid = out_valid;

endmodule

`default_nettype wire

FILE: rtl/core/hdm_checker.sv
// Port-level checker for the handler duration monitor, bound to the top level.
// Depends on hdm_pkg and handler_duration_monitor_assert.svh.
`default_nettype none

`include "handler_duration_monitor_assert.svh"

module hdm_checker (
  input wire                        clk,
  input wire                        rst,
  input wire                        in_valid,
  input wire                        in_ready,
  input wire [hdm_pkg::MODE_W-1:0]  in_mode,
  input wire                        out_valid,
  input wire                        out_ready,
  input wire                        out_kind,
  input wire [hdm_pkg::SRC_W-1:0]   out_source,
  input wire [hdm_pkg::CNT_W-1:0]   out_count,
  input wire [hdm_pkg::TS_W-1:0]    out_total,
  input wire                        out_last
);
  import hdm_pkg::*;

  logic dump_take;
  logic slow_beat;
  logic slow_clear;
  logic summary_beat;
  logic timer_src;

  assign dump_take    = in_valid && in_ready && (in_mode == MODE_DUMP);
  assign slow_beat    = out_valid && (out_kind == KIND_SLOW);
  assign slow_clear   = out_last && (out_count == '0) && (out_total == '0);
  assign summary_beat = out_valid && (out_kind == KIND_SUMMARY);
  assign timer_src    = out_source == SRC_TIMER;

  `HDM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "stalled beat dropped")

  `HDM_ASSERT_NEXT(a_dump_busy, dump_take, !in_ready, "input taken during a dump")

  `HDM_ASSERT_NOW(a_slow_form, slow_beat, slow_clear, "slow-event record malformed")

  `HDM_ASSERT_NOW(a_summary_last, summary_beat, out_last == timer_src, "summary last misplaced")

endmodule

bind handler_duration_monitor hdm_checker u_hdm_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_mode    (in_ch.mode),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_kind   (out_ch.record_kind),
  .out_source (out_ch.record_source),
  .out_count  (out_ch.event_count),
  .out_total  (out_ch.total_ns),
  .out_last   (out_ch.last)
);

`default_nettype wire
